FILE: rtl/core/argb_to_rgb565_dither_defines.svh
// -----------------------------------------------------------------------------
// argb_to_rgb565_dither_defines.svh
// assertion macros shared by the converter's fifo and front end rtl files
// -----------------------------------------------------------------------------
`ifndef ARGB_TO_RGB565_DITHER_DEFINES_SVH
`define ARGB_TO_RGB565_DITHER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define A2R_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define A2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition never holds
`define A2R_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/core/a2r_pkg.sv
// -----------------------------------------------------------------------------
// a2r_pkg
// types, constants and helper functions of the argb to rgb565 converter
// -----------------------------------------------------------------------------
`default_nettype none

package a2r_pkg;

  localparam logic [31:0] NOISE_SEED = 32'h8BAD_F00D;
  localparam logic [31:0] NOISE_TAPS = 32'h20AA_95B5;
  localparam logic [15:0] WHITE_565  = 16'hFFFF;
  localparam logic [7:0]  ALPHA_MAX  = 8'hFF;

  // pixel class decided in the front end
  typedef enum logic [1:0] {
    PX_CLEAR,
    PX_OPAQUE,
    PX_BLEND
  } px_kind_t;

  // one work entry between front and back end
  typedef struct packed {
    px_kind_t   kind;
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [2:0] nz_red;
    logic [1:0] nz_green;
    logic [2:0] nz_blue;
  } work_t;

  // one step of the noise shift register
  function automatic logic [31:0] noise_step(input logic [31:0] cur);
    logic [31:0] s;
    s = {cur[30:0], 1'b0};
    if ((s == 32'd0) || s[31]) begin
      s = s ^ NOISE_TAPS;
    end
    return s;
  endfunction

  // (c*a + (255-a)*255) >> 8, the sum never exceeds 255*255
  function automatic logic [7:0] blend_white(input logic [7:0] c, input logic [7:0] a);
    logic [7:0]  w;
    logic [15:0] ca;
    logic [15:0] ww;
    logic [15:0] sum;
    w   = ALPHA_MAX - a;
    ca  = {8'd0, c} * {8'd0, a};
    ww  = {w, 8'd0} - {8'd0, w};
    sum = ca + ww;
    return sum[15:8];
  endfunction

  // channel plus noise, saturated at 255
  function automatic logic [7:0] add_sat(input logic [7:0] c, input logic [2:0] nz);
    logic [8:0] sum;
    sum = {1'b0, c} + {6'd0, nz};
    return sum[8] ? ALPHA_MAX : sum[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/a2r_fifo.sv
// -----------------------------------------------------------------------------
// a2r_fifo
// small synchronous queue with combinational head read
// -----------------------------------------------------------------------------
`default_nettype none
`include "argb_to_rgb565_dither_defines.svh"

module a2r_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  `A2R_ASSERT_NEVER(a_fifo_count_range, count_r > CW'(DEPTH), "fifo count above depth")
  `A2R_ASSERT_IMPLIES(a_fifo_no_overrun, wr_en, !full, "write into full fifo")

endmodule

`default_nettype wire

FILE: rtl/core/a2r_front.sv
// -----------------------------------------------------------------------------
// a2r_front
// accepts pixels, classifies alpha and draws dither noise from the register
// -----------------------------------------------------------------------------
`default_nettype none
`include "argb_to_rgb565_dither_defines.svh"

module a2r_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  input  wire logic [31:0]   in_argb_pixel,
  input  wire logic          q_full,
  output logic               q_wr,
  output a2r_pkg::work_t     q_data
);

  import a2r_pkg::*;

  logic [31:0] noise_r, noise_nxt;
  logic [31:0] chain [9];
  logic        accept;
  px_kind_t    kind;
  logic [7:0]  alpha;

  assign accept = in_push && !q_full;
  assign alpha  = in_argb_pixel[31:24];

  always_comb begin
    if (alpha == '0) begin
      kind = PX_CLEAR;
    end else if (alpha == ALPHA_MAX) begin
      kind = PX_OPAQUE;
    end else begin
      kind = PX_BLEND;
    end
  end

  // eight register steps: 3 red, 2 green, 3 blue
  always_comb begin
    chain[0] = noise_r;
    for (int k = 0; k < 8; k++) begin
      chain[k+1] = noise_step(chain[k]);
    end
  end

  always_comb begin
    q_data.kind     = kind;
    q_data.alpha    = alpha;
    q_data.red      = in_argb_pixel[23:16];
    q_data.green    = in_argb_pixel[15:8];
    q_data.blue     = in_argb_pixel[7:0];
    q_data.nz_red   = chain[3][2:0];
    q_data.nz_green = chain[5][1:0];
    q_data.nz_blue  = chain[8][2:0];
  end

  assign q_wr      = accept;
  assign noise_nxt = (accept && (kind != PX_CLEAR)) ? chain[8] : noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      noise_r <= NOISE_SEED;
    end else begin
      noise_r <= noise_nxt;
    end
  end

  `A2R_ASSERT_NEXT(a_clear_keeps_noise, accept && (kind == PX_CLEAR), $stable(noise_r),
    "noise moved on transparent pixel")
  `A2R_ASSERT_NEVER(a_noise_nonzero, noise_r == 32'd0, "noise register reached zero")

endmodule

`default_nettype wire

FILE: rtl/core/a2r_back.sv
// -----------------------------------------------------------------------------
// a2r_back
// blends toward white, adds noise, saturates and packs rgb565
// -----------------------------------------------------------------------------
`default_nettype none

module a2r_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire a2r_pkg::work_t   q_head,
  output logic                  q_rd,
  input  wire logic             o_full,
  output logic                  o_wr,
  output logic [15:0]           o_data
);

  import a2r_pkg::*;

  logic       b1_valid_r, b1_valid_nxt;
  logic       b1_clear_r;
  logic [7:0] b1_red_r, b1_green_r, b1_blue_r;
  logic [2:0] b1_nz_red_r, b1_nz_blue_r;
  logic [1:0] b1_nz_green_r;
  logic [7:0] red_bl, green_bl, blue_bl;
  logic [7:0] red_d, green_d, blue_d;

  // blend stage: one 8x8 multiply per channel
  always_comb begin
    if (q_head.kind == PX_BLEND) begin
      red_bl   = blend_white(q_head.red, q_head.alpha);
      green_bl = blend_white(q_head.green, q_head.alpha);
      blue_bl  = blend_white(q_head.blue, q_head.alpha);
    end else begin
      red_bl   = q_head.red;
      green_bl = q_head.green;
      blue_bl  = q_head.blue;
    end
  end

  assign o_wr         = b1_valid_r && !o_full;
  assign q_rd         = !q_empty && (!b1_valid_r || !o_full);
  assign b1_valid_nxt = q_rd ? 1'b1 : (o_wr ? 1'b0 : b1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else begin
      b1_valid_r <= b1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      b1_clear_r    <= (q_head.kind == PX_CLEAR);
      b1_red_r      <= red_bl;
      b1_green_r    <= green_bl;
      b1_blue_r     <= blue_bl;
      b1_nz_red_r   <= q_head.nz_red;
      b1_nz_green_r <= q_head.nz_green;
      b1_nz_blue_r  <= q_head.nz_blue;
    end
  end

  // dither and pack stage
  assign red_d   = add_sat(b1_red_r, b1_nz_red_r);
  assign green_d = add_sat(b1_green_r, {1'b0, b1_nz_green_r});
  assign blue_d  = add_sat(b1_blue_r, b1_nz_blue_r);

  assign o_data = b1_clear_r ? WHITE_565 : {red_d[7:3], green_d[7:2], blue_d[7:3]};

endmodule

`default_nettype wire

FILE: rtl/core/argb_to_rgb565_dither.sv
// -----------------------------------------------------------------------------
// argb_to_rgb565_dither
// argb8888 to rgb565 converter with blend toward white and shift-register dither
// -----------------------------------------------------------------------------
//
// channel   ports                         handshake
// -------   ---------------------------   ------------------------------------
// input     in_argb_pixel [31:0]          taken when in_push && !in_full
// result    out_rgb565_pixel [15:0]       taken when out_pop && !out_empty
//
// sustained rate is one pixel per clock while out_pop drains the result queue; the
// noise register takes all eight steps for a non-transparent pixel in the cycle
// it is accepted; an accepted pixel then passes the work queue, the blend
// register and the result queue before it shows on out_rgb565_pixel
// reset loads the noise register with its seed and empties both queues
// with out_pop held low, QUEUE_DEPTH + 1 + OUT_DEPTH pixels are held before
// in_full rises; front and back end stall independently
// -----------------------------------------------------------------------------
`default_nettype none

module argb_to_rgb565_dither #(
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire logic [31:0] in_argb_pixel,
  output logic             in_full,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [15:0]      out_rgb565_pixel
);

  import a2r_pkg::*;

  localparam int WORK_W = $bits(work_t);

  // front end to work queue
  logic              mid_wr;
  work_t             mid_wr_data;
  logic              mid_full;
  // work queue to back end
  logic              mid_rd;
  logic [WORK_W-1:0] mid_rd_data;
  logic              mid_empty;
  work_t             mid_head;
  // back end to result queue
  logic              res_wr;
  logic [15:0]       res_wr_data;
  logic              res_full;

  assign in_full  = mid_full;
  assign mid_head = work_t'(mid_rd_data);

  // classify alpha and draw noise per accepted non-transparent pixel
  a2r_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_argb_pixel (in_argb_pixel),
    .q_full        (mid_full),
    .q_wr          (mid_wr),
    .q_data        (mid_wr_data)
  );

  // decouples the noise draw from the arithmetic
  a2r_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (WORK_W)
  ) u_work_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_wr),
    .wr_data (WORK_W'(mid_wr_data)),
    .full    (mid_full),
    .rd_en   (mid_rd),
    .rd_data (mid_rd_data),
    .empty   (mid_empty)
  );

  // blend, dither, saturate and pack
  a2r_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (mid_empty),
    .q_head  (mid_head),
    .q_rd    (mid_rd),
    .o_full  (res_full),
    .o_wr    (res_wr),
    .o_data  (res_wr_data)
  );

  // finished results wait here until popped
  a2r_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH (16)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_wr_data),
    .full    (res_full),
    .rd_en   (out_pop),
    .rd_data (out_rgb565_pixel),
    .empty   (out_empty)
  );

endmodule

`default_nettype wire
